// ----- rtl/core/tsv_pkg.sv -----
// Shared types, constants and helpers for the TCP-over-IPv6 segment validator.
`default_nettype none

package tsv_pkg;

   // Segment length limits and field positions
   localparam int unsigned LEN_W = 16;
   localparam logic [LEN_W-1:0] MAX_LEN = 16'd65535;
   localparam logic [LEN_W-1:0] MIN_SEGMENT = 16'd20;
   localparam logic [LEN_W-1:0] PORT_BYTES = 16'd4;
   localparam logic [LEN_W-1:0] HDR_LEN_POS = 16'd12;
   localparam logic [LEN_W-1:0] FLAGS_POS = 16'd13;
   localparam logic [3:0] MIN_OFFSET = 4'd5;

   // Checksum arithmetic
   localparam int unsigned WORD_W = 16;
   localparam int unsigned HALVES = 4;
   localparam int unsigned PART_W = WORD_W + 2;
   localparam int unsigned ADDR_SUM_W = PART_W + 2;
   localparam int unsigned ACC_W = 32;
   localparam logic [WORD_W-1:0] NEXT_HEADER_TCP = 16'd6;
   localparam logic [WORD_W-1:0] SUM_GOOD = 16'hFFFF;

   // Flag bit positions
   localparam int unsigned FIN_BIT = 0;
   localparam int unsigned SYN_BIT = 1;

   typedef enum logic [2:0] {
      VERDICT_ACCEPT       = 3'd0,
      VERDICT_TOO_SHORT    = 3'd1,
      VERDICT_BAD_HDR_LEN  = 3'd2,
      VERDICT_BAD_FLAGS    = 3'd3,
      VERDICT_BAD_CHECKSUM = 3'd4
   } verdict_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [63:0] src_addr_hi;
      logic [63:0] src_addr_lo;
      logic [63:0] dst_addr_hi;
      logic [63:0] dst_addr_lo;
   } req_type;

   typedef struct packed {
      verdict_type verdict;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [7:0]  flag_bits;
   } rsp_type;

   // One byte on its way to the accumulator, with its pseudo-header address sum
   typedef struct packed {
      logic [7:0]            data_byte;
      logic                  last_byte;
      logic [ADDR_SUM_W-1:0] addr_sum;
   } beat_type;

   // Segment state captured at the final byte
   typedef struct packed {
      logic [ACC_W-1:0] acc;
      logic [LEN_W-1:0] len;
      logic [7:0]       held;
      logic [3:0]       hdr;
      logic [7:0]       flags;
      logic [31:0]      ports;
   } snap_type;

   // Plain sum of the four 16-bit words of a 64-bit address half
   function automatic logic [PART_W-1:0] sum_quad(input logic [63:0] half);
      return PART_W'(half[63:48]) + PART_W'(half[47:32])
           + PART_W'(half[31:16]) + PART_W'(half[15:0]);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tsv_addr_sum.sv -----
// Two-stage adder tree over the IPv6 source and destination addresses.
`default_nettype none

module tsv_addr_sum import tsv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  req_type  in_item,
   output logic     out_valid,
   output beat_type out_beat
);

   logic [PART_W-1:0]     part_in [HALVES];
   logic [PART_W-1:0]     part_ff [HALVES];
   logic                  mid_valid_ff;
   logic [7:0]            mid_byte_ff;
   logic                  mid_last_ff;
   logic [ADDR_SUM_W-1:0] total_in;
   logic                  out_valid_ff;
   beat_type              out_beat_ff;

   always_comb begin
      part_in[0] = sum_quad(in_item.src_addr_hi);
      part_in[1] = sum_quad(in_item.src_addr_lo);
      part_in[2] = sum_quad(in_item.dst_addr_hi);
      part_in[3] = sum_quad(in_item.dst_addr_lo);
      total_in = ADDR_SUM_W'(part_ff[0]) + ADDR_SUM_W'(part_ff[1])
               + ADDR_SUM_W'(part_ff[2]) + ADDR_SUM_W'(part_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         mid_valid_ff <= in_valid;
         out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         part_ff               <= part_in;
         mid_byte_ff           <= in_item.data_byte;
         mid_last_ff           <= in_item.last_byte;
         out_beat_ff.data_byte <= mid_byte_ff;
         out_beat_ff.last_byte <= mid_last_ff;
         out_beat_ff.addr_sum  <= total_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_beat  = out_beat_ff;

endmodule

`default_nettype wire

// ----- rtl/core/tsv_seg_accum.sv -----
// Per-segment state: byte count, running word sum and header captures.
`default_nettype none

module tsv_seg_accum import tsv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  beat_type in_beat,
   output logic     snap_valid,
   output snap_type snap
);

   logic [LEN_W-1:0] count_ff, count_upd, count_in;
   logic [ACC_W-1:0] acc_ff, acc_base, acc_upd, acc_in;
   logic [7:0]       held_ff, held_upd, held_in;
   logic [3:0]       hdr_ff, hdr_upd, hdr_in;
   logic [7:0]       flags_ff, flags_upd, flags_in;
   logic [31:0]      ports_ff, ports_upd, ports_in;
   logic             snap_valid_ff;
   snap_type         snap_ff, snap_in;

   always_comb begin
      // Fold the address sum in on the first byte of a segment
      acc_base  = (count_ff == '0) ? ACC_W'(in_beat.addr_sum) : acc_ff;
      acc_upd   = acc_base;
      count_upd = count_ff;
      held_upd  = held_ff;
      hdr_upd   = hdr_ff;
      flags_upd = flags_ff;
      ports_upd = ports_ff;

      // Drop bytes past the length limit
      if (count_ff < MAX_LEN) begin
         if (!count_ff[0]) begin
            held_upd = in_beat.data_byte;
         end else begin
            acc_upd = acc_base + ACC_W'({held_ff, in_beat.data_byte});
         end

         if (count_ff < PORT_BYTES) begin
            ports_upd[{2'd3 - count_ff[1:0], 3'b000} +: 8] = in_beat.data_byte;
         end

         case (count_ff)
            HDR_LEN_POS: begin
               hdr_upd = in_beat.data_byte[7:4];
            end
            FLAGS_POS: begin
               flags_upd = in_beat.data_byte;
            end
            default: begin
            end
         endcase

         count_upd = count_ff + LEN_W'(1);
      end

      snap_in.acc   = acc_upd;
      snap_in.len   = count_upd;
      snap_in.held  = held_upd;
      snap_in.hdr   = hdr_upd;
      snap_in.flags = flags_upd;
      snap_in.ports = ports_upd;

      // Clear everything once the segment closes
      if (in_beat.last_byte) begin
         acc_in   = '0;
         count_in = '0;
         held_in  = '0;
         hdr_in   = '0;
         flags_in = '0;
         ports_in = '0;
      end else begin
         acc_in   = acc_upd;
         count_in = count_upd;
         held_in  = held_upd;
         hdr_in   = hdr_upd;
         flags_in = flags_upd;
         ports_in = ports_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         count_ff      <= '0;
         held_ff       <= '0;
         hdr_ff        <= '0;
         flags_ff      <= '0;
         ports_ff      <= '0;
         snap_valid_ff <= 1'b0;
      end else if (advance) begin
         snap_valid_ff <= in_valid && in_beat.last_byte;
         if (in_valid) begin
            acc_ff   <= acc_in;
            count_ff <= count_in;
            held_ff  <= held_in;
            hdr_ff   <= hdr_in;
            flags_ff <= flags_in;
            ports_ff <= ports_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         snap_ff <= snap_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

`default_nettype wire

// ----- rtl/core/tsv_verdict.sv -----
// Pseudo-header completion, checksum fold and verdict selection.
`default_nettype none

module tsv_verdict import tsv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     snap_valid,
   input  snap_type snap,
   output logic     res_valid,
   output rsp_type  res
);

   logic [ACC_W-1:0]  pad;
   logic [ACC_W-1:0]  total_in, total_ff;
   logic              res_valid_ff;
   snap_type          info_ff;
   logic [WORD_W:0]   fold_lo;
   logic [WORD_W-1:0] fold_sum;
   logic              flags_bad;

   always_comb begin
      // Pad an odd final byte with a zero low byte
      pad = snap.len[0] ? ACC_W'({snap.held, 8'h00}) : '0;
      total_in = snap.acc + pad + ACC_W'(snap.len) + ACC_W'(NEXT_HEADER_TCP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (advance) begin
         res_valid_ff <= snap_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         total_ff <= total_in;
         info_ff  <= snap;
      end
   end

   always_comb begin
      // End-around carry, twice, settles any 32-bit sum into 16 bits
      fold_lo  = {1'b0, total_ff[WORD_W-1:0]} + {1'b0, total_ff[ACC_W-1:WORD_W]};
      fold_sum = fold_lo[WORD_W-1:0] + WORD_W'(fold_lo[WORD_W]);

      flags_bad = (info_ff.flags[SYN_BIT] && info_ff.flags[FIN_BIT])
                || (info_ff.flags == '0);

      if (info_ff.len < MIN_SEGMENT) begin
         res.verdict = VERDICT_TOO_SHORT;
      end else if (info_ff.hdr < MIN_OFFSET
                   || LEN_W'({info_ff.hdr, 2'b00}) > info_ff.len) begin
         res.verdict = VERDICT_BAD_HDR_LEN;
      end else if (flags_bad) begin
         res.verdict = VERDICT_BAD_FLAGS;
      end else if (fold_sum != SUM_GOOD) begin
         res.verdict = VERDICT_BAD_CHECKSUM;
      end else begin
         res.verdict = VERDICT_ACCEPT;
      end

      res.source_port = info_ff.ports[31:16];
      res.dest_port   = info_ff.ports[15:0];
      res.flag_bits   = info_ff.flags;
   end

   assign res_valid = res_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/core/tcp6_segment_validator_core.sv -----
// Top level of the TCP-over-IPv6 segment validator.
//
// Takes a received TCP segment one byte per request, last_byte marking the
// final byte, and returns one verdict per segment with the source port,
// destination port and flag byte. The IPv6 addresses are sampled with the
// first byte of each segment. The block accepts one request every clock
// cycle; it stops taking requests only when a verdict reaches the output
// register while the previous verdict there has not been taken. After the
// request carrying the last byte is accepted, its verdict passes through the
// input register, two address adder-tree stages, the segment accumulator,
// the pseudo-header completion add, then the output register. The per-byte
// rate is set by one 32-bit add in the accumulator. Bytes beyond 65535 are
// counted as the limit and left out of the checksum and captures. Ports and
// flags of a segment too short to carry them read as zero.
`default_nettype none

module tcp6_segment_validator_core import tsv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   logic     advance;
   logic     in_valid_ff;
   req_type  in_item_ff;
   logic     beat_valid;
   beat_type beat;
   logic     snap_valid;
   snap_type snap;
   logic     res_valid;
   rsp_type  res;
   logic     rsp_valid_ff;
   rsp_type  rsp_item_ff;

   // Hold the whole pipe only when a new verdict would overwrite one still waiting
   assign advance   = !(res_valid && rsp_valid_ff && !rsp_ready);
   assign req_ready = advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_item_ff <= req_item;
      end
   end

   tsv_addr_sum u_addr_sum (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (in_valid_ff),
      .in_item   (in_item_ff),
      .out_valid (beat_valid),
      .out_beat  (beat)
   );

   tsv_seg_accum u_seg_accum (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (beat_valid),
      .in_beat    (beat),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   tsv_verdict u_verdict (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .snap_valid (snap_valid),
      .snap       (snap),
      .res_valid  (res_valid),
      .res        (res)
   );

   // Output register: drop on handshake, load a new verdict when one arrives
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_item_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

// ----- rtl/core/tsv_checker.sv -----
// Port-level checks for the segment validator, bound to its top level.
`default_nettype none

module tsv_checker import tsv_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_item,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_item
);

   // A waiting verdict holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("verdict dropped or changed while stalled");

   // With the output empty, requests are never refused
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty output");

   // An accepted segment carries sane flags
   a_accept_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.verdict == VERDICT_ACCEPT
      |-> rsp_item.flag_bits != 8'h00
          && !(rsp_item.flag_bits[SYN_BIT] && rsp_item.flag_bits[FIN_BIT]))
      else $error("accepted segment with bad flags");

   // Verdict codes stay within the defined set
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.verdict == VERDICT_ACCEPT
                 || rsp_item.verdict == VERDICT_TOO_SHORT
                 || rsp_item.verdict == VERDICT_BAD_HDR_LEN
                 || rsp_item.verdict == VERDICT_BAD_FLAGS
                 || rsp_item.verdict == VERDICT_BAD_CHECKSUM)
      else $error("undefined verdict code");

   // A refused request only happens with a verdict waiting that is not taken
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without output back-pressure");

endmodule

bind tcp6_segment_validator_core tsv_checker u_checker (.*);

`default_nettype wire
